/* rtl/wudvr_pkg.sv */
// Shared types and constants for the windowed up/down volume ratio block.
package wudvr_pkg;

    localparam int CFG_W          = 9;
    localparam int RATIO_W        = 12;
    localparam int DIV_CNT_W      = 4;
    localparam int DEFAULT_WINDOW = 32;
    localparam int MIN_WINDOW     = 2;
    localparam int MIN_VALID_BARS = 3;
    localparam logic [RATIO_W-1:0] RATIO_SCALE = 12'd2560;
    // 2560 = 2^11 + 2^9, so scaling by it is two shifts and one add.
    localparam int SCALE_SHIFT_HI = 11;
    localparam int SCALE_SHIFT_LO = 9;

    typedef struct packed {
        logic signed [31:0] close_price;
        logic [31:0]        volume;
    } t_bar;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_size;
        logic               valid_res;
    } t_ratio;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_EVICT = 4'b0010,
        F_ADD   = 4'b0100,
        F_PUSH  = 4'b1000
    } t_fstate;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_PREP  = 5'b00010,
        B_SCALE = 5'b00100,
        B_DIV   = 5'b01000,
        B_DONE  = 5'b10000
    } t_bstate;

endpackage

/* rtl/wudvr_front.sv */
// Front end: accepts bars, classifies them and keeps the windowed up/down sums.
module wudvr_front #(
    parameter int MAX_WINDOW  = 256,
    parameter int VOLUME_BITS = 32,
    parameter int SUM_W       = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wudvr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    input  wudvr_pkg::t_bar                 i_bar,
    output logic                            o_stall,
    input  wudvr_pkg::t_q_stat              i_q_stat,
    output logic                            o_push,
    output logic [2*SUM_W:0]                o_push_data
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int BW    = $clog2(MAX_WINDOW + 2);
    localparam int VW    = VOLUME_BITS;
    localparam int ENT_W = VOLUME_BITS + 1;

    wudvr_pkg::t_fstate r_state, n_state;

    logic [wudvr_pkg::CFG_W-1:0] r_window;
    logic signed [31:0]          r_prev;
    logic [SUM_W-1:0]            r_up;
    logic [SUM_W-1:0]            r_down;
    logic [BW-1:0]               r_bars;
    logic [PTR_W-1:0]            r_ptr;
    logic [VW-1:0]               r_vol;
    logic                        r_down_flag;
    logic                        r_active;
    logic                        r_evict;
    logic [ENT_W-1:0]            r_old;

    // Ring of past changes: top bit marks down-volume.
    logic [ENT_W-1:0] r_ring [MAX_WINDOW];

    logic [31:0]      w_win;
    logic [31:0]      w_n;
    logic [PTR_W:0]   n_eff;
    logic [PTR_W:0]   idx_sum;
    logic [PTR_W:0]   idx_wrap;
    logic [PTR_W-1:0] rd_addr;
    logic             evict_now;
    logic             accept;

    always_comb begin
        w_win = (r_window < wudvr_pkg::CFG_W'(wudvr_pkg::MIN_WINDOW))
              ? 32'(wudvr_pkg::DEFAULT_WINDOW) : 32'(r_window);
        w_n   = (w_win > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : w_win;
        n_eff = w_n[PTR_W:0];
        // Oldest change in the window sits n entries behind the write pointer.
        idx_sum  = {1'b0, r_ptr} + ((PTR_W+1)'(MAX_WINDOW) - n_eff);
        idx_wrap = (idx_sum >= (PTR_W+1)'(MAX_WINDOW))
                 ? idx_sum - (PTR_W+1)'(MAX_WINDOW) : idx_sum;
        rd_addr  = idx_wrap[PTR_W-1:0];
        evict_now = (r_bars != '0) && (32'(r_bars) > w_n);
    end

    assign accept  = (r_state == wudvr_pkg::F_IDLE) && i_valid && !i_q_stat.full;
    assign o_stall = (r_state != wudvr_pkg::F_IDLE) || i_q_stat.full;
    assign o_push  = (r_state == wudvr_pkg::F_PUSH);
    assign o_push_data = {r_up, r_down,
                          (32'(r_bars) >= 32'(wudvr_pkg::MIN_VALID_BARS))};

    always_comb begin
        n_state = r_state;
        case (r_state)
            wudvr_pkg::F_IDLE:  if (accept) n_state = wudvr_pkg::F_EVICT;
            wudvr_pkg::F_EVICT: n_state = wudvr_pkg::F_ADD;
            wudvr_pkg::F_ADD:   n_state = wudvr_pkg::F_PUSH;
            wudvr_pkg::F_PUSH:  n_state = wudvr_pkg::F_IDLE;
            default:            n_state = wudvr_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wudvr_pkg::F_IDLE;
            r_window <= wudvr_pkg::CFG_W'(wudvr_pkg::DEFAULT_WINDOW);
            r_prev   <= '0;
            r_up     <= '0;
            r_down   <= '0;
            r_bars   <= '0;
            r_ptr    <= '0;
        end else if (i_cfg_we) begin
            r_state  <= wudvr_pkg::F_IDLE;
            r_window <= i_cfg_data;
            r_prev   <= '0;
            r_up     <= '0;
            r_down   <= '0;
            r_bars   <= '0;
            r_ptr    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                wudvr_pkg::F_IDLE: begin
                    if (accept) begin
                        r_prev <= i_bar.close_price;
                        if (r_bars != BW'(MAX_WINDOW + 1)) begin
                            r_bars <= r_bars + BW'(1);
                        end
                    end
                end
                wudvr_pkg::F_EVICT: begin
                    if (r_evict) begin
                        if (r_old[VW]) begin
                            r_down <= r_down - SUM_W'(r_old[VW-1:0]);
                        end else begin
                            r_up <= r_up - SUM_W'(r_old[VW-1:0]);
                        end
                    end
                end
                wudvr_pkg::F_ADD: begin
                    if (r_active) begin
                        r_ptr <= (r_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
                        if (r_down_flag) begin
                            r_down <= r_down + SUM_W'(r_vol);
                        end else begin
                            r_up <= r_up + SUM_W'(r_vol);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Captured request fields and the ring itself.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vol       <= VW'(i_bar.volume);
            r_down_flag <= (i_bar.close_price < r_prev);
            r_active    <= (r_bars != '0);
            r_evict     <= evict_now;
            r_old       <= r_ring[rd_addr];
        end
        if ((r_state == wudvr_pkg::F_ADD) && r_active) begin
            r_ring[r_ptr] <= {r_down_flag, r_vol};
        end
    end

endmodule

/* rtl/wudvr_queue.sv */
// Two-entry queue between the front end and the divider back end.
module wudvr_queue #(
    parameter int WIDTH = 81
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output wudvr_pkg::t_q_stat   o_stat
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/wudvr_back.sv */
// Back end: scales the up/down imbalance and divides it by the total, one bit a cycle.
module wudvr_back #(
    parameter int SUM_W = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wudvr_pkg::t_q_stat         i_q_stat,
    input  logic [2*SUM_W:0]           i_q_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output wudvr_pkg::t_ratio          o_res
);

    localparam int RW    = wudvr_pkg::RATIO_W;
    localparam int NUM_W = SUM_W + RW;

    wudvr_pkg::t_bstate r_state, n_state;

    logic [SUM_W-1:0]                 r_up;
    logic [SUM_W-1:0]                 r_down;
    logic                             r_vflag;
    logic [SUM_W-1:0]                 r_total;
    logic [SUM_W-1:0]                 r_diff;
    logic [SUM_W-1:0]                 r_rem;
    logic [RW-1:0]                    r_quo;
    logic [wudvr_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                             r_out_valid;
    wudvr_pkg::t_ratio                r_out;

    logic [NUM_W-1:0] num;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   trial_sub;
    logic             q_bit;
    logic             out_free;
    logic [RW-1:0]    ratio_clamped;

    assign o_pop    = (r_state == wudvr_pkg::B_IDLE) && !i_q_stat.empty;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_comb begin
        num = (NUM_W'(r_diff) << wudvr_pkg::SCALE_SHIFT_HI)
            + (NUM_W'(r_diff) << wudvr_pkg::SCALE_SHIFT_LO);
        // Restoring step: remainder stays below the total between steps.
        trial     = {r_rem, r_quo[RW-1]};
        trial_sub = trial - {1'b0, r_total};
        q_bit     = (trial >= {1'b0, r_total});
        ratio_clamped = (r_quo > wudvr_pkg::RATIO_SCALE) ? wudvr_pkg::RATIO_SCALE : r_quo;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wudvr_pkg::B_IDLE:  if (o_pop) n_state = wudvr_pkg::B_PREP;
            wudvr_pkg::B_PREP:  n_state = wudvr_pkg::B_SCALE;
            wudvr_pkg::B_SCALE: n_state = wudvr_pkg::B_DIV;
            wudvr_pkg::B_DIV: begin
                if (r_cnt == wudvr_pkg::DIV_CNT_W'(RW - 1)) n_state = wudvr_pkg::B_DONE;
            end
            wudvr_pkg::B_DONE:  if (out_free) n_state = wudvr_pkg::B_IDLE;
            default:            n_state = wudvr_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wudvr_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == wudvr_pkg::B_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == wudvr_pkg::B_SCALE) begin
                r_cnt <= '0;
            end else if (r_state == wudvr_pkg::B_DIV) begin
                r_cnt <= r_cnt + wudvr_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wudvr_pkg::B_IDLE: begin
                if (o_pop) begin
                    {r_up, r_down, r_vflag} <= i_q_data;
                end
            end
            wudvr_pkg::B_PREP: begin
                r_total <= r_up + r_down;
                r_diff  <= (r_up >= r_down) ? r_up - r_down : r_down - r_up;
            end
            wudvr_pkg::B_SCALE: begin
                r_rem <= num[NUM_W-1:RW];
                r_quo <= num[RW-1:0];
            end
            wudvr_pkg::B_DIV: begin
                r_rem <= q_bit ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
                r_quo <= {r_quo[RW-2:0], q_bit};
            end
            wudvr_pkg::B_DONE: begin
                if (out_free) begin
                    r_out.valid_res  <= r_vflag;
                    r_out.ratio_size <= (r_vflag && (r_total != '0)) ? ratio_clamped : '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/windowed_up_down_volume_ratio.sv */
// Top level of the windowed up/down volume ratio block.
//
// Each input request is one bar (close price, volume) on i_bar, taken when
// i_valid is high and o_stall is low. Each bar yields exactly one result on
// o_res, taken when o_valid is high and i_stall is low. The result is
// |up - down| * 10 / (up + down) in units of 1/256, summed over the last
// window_length price changes, and a flag that rises from the third bar on.
// The window register must be written through i_cfg_we / i_cfg_data only while
// the block is idle (not enforced by it); a write also clears the stream state.
//
// The front end takes each bar through ring read, eviction, update and
// hand-off; the back end finishes one bar, through its 12-step restoring
// divider, before it pops the next one from the queue. A two-entry queue
// between the two parts lets the front end run ahead while results wait.
// A stalled result sits in the output register while the divider finishes
// the next bar; the block then stalls its input once the queue fills.
// Reset is synchronous and active low: the window returns to 32, the sums,
// bar count and ring pointer clear, and no result is pending. The ring
// needs no clearing pass; entries are read only after being written.
module windowed_up_down_volume_ratio #(
    parameter int MAX_WINDOW  = 256,
    parameter int VOLUME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wudvr_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  wudvr_pkg::t_bar             i_bar,
    output logic                        o_valid,
    input  logic                        i_stall,
    output wudvr_pkg::t_ratio           o_res
);

    // Wide enough for a full window of maximum volumes.
    localparam int SUM_W = VOLUME_BITS + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1);
    localparam int Q_W   = 2 * SUM_W + 1;

    logic               q_push;
    logic               q_pop;
    logic [Q_W-1:0]     q_wdata;
    logic [Q_W-1:0]     q_rdata;
    wudvr_pkg::t_q_stat q_stat;

    wudvr_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .VOLUME_BITS (VOLUME_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_bar       (i_bar),
        .o_stall     (o_stall),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_wdata)
    );

    wudvr_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    wudvr_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (q_rdata),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (o_res)
    );

    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    // The back end must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // After taking a bar the front end is busy, so it must stall the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_cfg_we) |=> o_stall)
        else $error("input not stalled after a request");

    // A result never exceeds the clamp value.
    a_ratio_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.ratio_size <= wudvr_pkg::RATIO_SCALE))
        else $error("ratio above clamp");

endmodule
